// File: hdl/gvtc_pkg.sv
package gvtc_pkg;

  // tag mask width and per-tag counter widths
  localparam int MASK_TAGS  = 16;
  localparam int TAG_BITS   = 5;
  localparam int TALLY_BITS = 32;
  localparam int TIDX_BITS  = 4;

  typedef enum logic [2:0] {
    CMD_COUNT  = 3'd0,
    CMD_CHOOSE = 3'd1,
    CMD_MARK   = 3'd2,
    CMD_LEAF   = 3'd3,
    CMD_SEED   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // control of the shared best-tag compare unit
  typedef struct packed {
    logic clear;
    logic step;
    logic use_tally;
    logic cand_ok;
  } best_ctl_t;

endpackage

// File: hdl/gvtc_tally.sv
module gvtc_tally
  import gvtc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  logic [MASK_TAGS-1:0]  lane_inc,
  input  logic [TIDX_BITS-1:0]  rd_idx,
  output logic [TALLY_BITS-1:0] rd_data
);

  logic [TALLY_BITS-1:0] tally [MASK_TAGS];

  // one saturating counter per tag, all lanes update together
  for (genvar i = 0; i < MASK_TAGS; i++) begin : g_lane
    logic [TALLY_BITS-1:0] base;
    assign base = clear ? '0 : tally[i];
    always_ff @(posedge clk) begin
      if (rst) begin
        tally[i] <= '0;
      end else if (lane_inc[i]) begin
        tally[i] <= (base != '1) ? base + TALLY_BITS'(1) : base;
      end else if (clear) begin
        tally[i] <= '0;
      end
    end
  end

  assign rd_data = tally[rd_idx];

endmodule

// File: hdl/gvtc_loads.sv
module gvtc_loads #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 40
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [$clog2(DEPTH)-1:0] rd_idx,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     bump,
  input  logic [$clog2(DEPTH)-1:0] bump_idx,
  input  logic [WIDTH-1:0]         bump_val
);

  logic [WIDTH-1:0] load [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        load[i] <= '0;
      end
    end else if (bump) begin
      // saturating increment of the value read earlier
      load[bump_idx] <= (bump_val != '1) ? bump_val + WIDTH'(1) : bump_val;
    end
  end

  assign rd_data = load[rd_idx];

endmodule

// File: hdl/gvtc_best.sv
module gvtc_best
  import gvtc_pkg::*;
#(
  parameter int LOAD_W = 40
) (
  input  logic                  clk,
  input  logic                  rst,
  input  best_ctl_t             ctl,
  input  logic [TAG_BITS-1:0]   cand_tag,
  input  logic [TALLY_BITS-1:0] cand_tally,
  input  logic [LOAD_W-1:0]     cand_load,
  output logic [TAG_BITS-1:0]   best_tag,
  output logic [LOAD_W-1:0]     best_load
);

  logic [TALLY_BITS-1:0] best_tally;
  logic                  take;

  // more hits wins, then less load; equal keeps the earlier tag
  always_comb begin
    take = ctl.step && ctl.cand_ok &&
           ((best_tag == '0) ||
            (ctl.use_tally && (cand_tally > best_tally)) ||
            ((!ctl.use_tally || (cand_tally == best_tally)) && (cand_load < best_load)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_tag <= '0;
    end else if (ctl.clear) begin
      best_tag <= '0;
    end else if (take) begin
      best_tag <= cand_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_tally <= cand_tally;
      best_load  <= cand_load;
    end
  end

endmodule

// File: hdl/greedy_vertex_tag_chooser.sv
// Greedy vertex tag chooser: the per-vertex tag selection engine of a greedy
// vertex-cut partitioner. Each input beat carries one command. Count beats
// update all per-tag neighbor tallies at once, so a stream of count beats
// runs at one beat per clock and gives no result beat. Choose and leaf
// assign walk tags 1..n through one shared compare unit, one tag per cycle,
// where n is the smaller of num_tags and the number of load counters: such a
// beat goes through accept, n scan steps and finish. Mark and seed go from
// accept straight to finish. Choose, leaf assign, mark and seed each give exactly
// one result beat; the finish cycle waits only if the output register still
// holds an untaken beat. Tallies saturate at 2^32-1, loads at all ones.
// num_tags may only be written while the block is idle.
module greedy_vertex_tag_chooser
  import gvtc_pkg::*;
#(
  parameter int MAX_TAGS  = 16,
  parameter int LOAD_BITS = 40
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_wen,
  input  logic [TAG_BITS-1:0]  cfg_wdata,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           command,
  input  logic                 first_item,
  input  logic                 last_item,
  input  logic [MASK_TAGS-1:0] neighbor_tags,
  input  logic [MASK_TAGS-1:0] own_tags,
  input  logic                 edge_covered,
  input  logic                 neighbor_degree_one,
  input  logic [TAG_BITS-1:0]  seed_tag,
  // output channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [TAG_BITS-1:0]  chosen_tag,
  output logic [MASK_TAGS-1:0] own_tags_out,
  output logic                 load_added,
  output logic                 edge_covered_out,
  output logic                 all_covered
);

  // number of load counters actually kept
  localparam int LT  = (MAX_TAGS < MASK_TAGS) ? MAX_TAGS : MASK_TAGS;
  localparam int LIW = $clog2(LT);

  state_t state, state_next;

  logic [TAG_BITS-1:0]   num_tags;
  logic [TAG_BITS-1:0]   n_tags;
  logic [TAG_BITS-1:0]   scan_tag;
  logic [TAG_BITS-1:0]   scan_m1;
  logic [TAG_BITS-1:0]   current_choice;
  logic                  any_uncovered_seen;

  // latched command beat
  logic [2:0]            cmd_q;
  logic                  first_q, last_q, cov_q, deg1_q;
  logic [MASK_TAGS-1:0]  nt_q, own_q;
  logic [TAG_BITS-1:0]   seed_q;

  logic                  accept, out_free, fin_fire;
  logic                  is_choose, is_leaf, is_mark, is_seed, seed_ok;

  // shared unit and stores
  best_ctl_t             best_ctl;
  logic [TAG_BITS-1:0]   best_tag;
  logic [LOAD_BITS-1:0]  best_load;
  logic [TALLY_BITS-1:0] tally_rd;
  logic [MASK_TAGS-1:0]  lane_inc;
  logic                  tally_clear;
  logic [LIW-1:0]        ld_rd_idx;
  logic [LOAD_BITS-1:0]  ld_rd;

  // result path
  logic [TAG_BITS-1:0]   sel_tag, sel_m1, cc_m1;
  logic [MASK_TAGS-1:0]  tag_bit;
  logic                  add_load, bump;
  logic [LOAD_BITS-1:0]  bump_val;
  logic                  mark_res, aus_next;

  assign n_tags   = (num_tags > TAG_BITS'(LT)) ? TAG_BITS'(LT) : num_tags;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign fin_fire = (state == ST_FINISH) && out_free;
  assign scan_m1  = scan_tag - TAG_BITS'(1);

  assign is_choose = (cmd_q == CMD_CHOOSE);
  assign is_leaf   = (cmd_q == CMD_LEAF);
  assign is_mark   = (cmd_q == CMD_MARK);
  assign is_seed   = (cmd_q == CMD_SEED);
  assign seed_ok   = (seed_q != '0) && (seed_q <= n_tags);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (command)
            CMD_CHOOSE, CMD_LEAF: state_next = (n_tags == '0) ? ST_FINISH : ST_SCAN;
            CMD_MARK, CMD_SEED:   state_next = ST_FINISH;
            default:              state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_tag == n_tags) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs of the sequencer
  always_comb begin
    in_stall           = (state != ST_IDLE);
    best_ctl.clear     = accept;
    best_ctl.step      = (state == ST_SCAN);
    best_ctl.use_tally = is_choose;
    best_ctl.cand_ok   = is_choose || nt_q[scan_m1[TIDX_BITS-1:0]];
    // the one load read port serves the scan, and the seed on finish
    ld_rd_idx = (state == ST_SCAN) ? scan_m1[LIW-1:0] : sel_m1[LIW-1:0];
    tally_clear = accept && (command == CMD_COUNT) && first_item;
  end

  // count beats bump the tally lane of every neighbor tag in use at once, unless the edge is covered
  for (genvar i = 0; i < MASK_TAGS; i++) begin : g_inc
    assign lane_inc[i] = accept && (command == CMD_COUNT) && !edge_covered &&
                         neighbor_tags[i] && (TAG_BITS'(i) < n_tags);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_tag <= '0;
    end else if (accept) begin
      scan_tag <= TAG_BITS'(1);
    end else if (state == ST_SCAN) begin
      scan_tag <= scan_tag + TAG_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= command;
      first_q <= first_item;
      last_q  <= last_item;
      nt_q    <= neighbor_tags;
      own_q   <= own_tags;
      cov_q   <= edge_covered;
      deg1_q  <= neighbor_degree_one;
      seed_q  <= seed_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_tags <= TAG_BITS'(8);
    end else if (cfg_wen) begin
      num_tags <= cfg_wdata;
    end
  end

  gvtc_tally u_tally (
    .clk      (clk),
    .rst      (rst),
    .clear    (tally_clear),
    .lane_inc (lane_inc),
    .rd_idx   (scan_m1[TIDX_BITS-1:0]),
    .rd_data  (tally_rd)
  );

  gvtc_loads #(
    .DEPTH (LT),
    .WIDTH (LOAD_BITS)
  ) u_loads (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (ld_rd_idx),
    .rd_data  (ld_rd),
    .bump     (bump),
    .bump_idx (sel_m1[LIW-1:0]),
    .bump_val (bump_val)
  );

  gvtc_best #(
    .LOAD_W (LOAD_BITS)
  ) u_best (
    .clk        (clk),
    .rst        (rst),
    .ctl        (best_ctl),
    .cand_tag   (scan_tag),
    .cand_tally (tally_rd),
    .cand_load  (ld_rd),
    .best_tag   (best_tag),
    .best_load  (best_load)
  );

  // result of the finish cycle
  always_comb begin
    if (is_choose || is_leaf) begin
      sel_tag = best_tag;
    end else if (is_seed && seed_ok) begin
      sel_tag = seed_q;
    end else begin
      sel_tag = '0;
    end
    sel_m1   = sel_tag - TAG_BITS'(1);
    tag_bit  = (sel_tag != '0) ? (MASK_TAGS'(1) << sel_m1[TIDX_BITS-1:0]) : '0;
    // a valid seed always counts load; choose and leaf only for a new tag
    add_load = is_seed ? seed_ok : ((sel_tag != '0) && ((own_q & tag_bit) == '0));
    bump     = fin_fire && add_load;
    bump_val = is_seed ? ld_rd : best_load;

    // mark: covered already, or the leaf neighbor, or it holds our choice
    cc_m1    = current_choice - TAG_BITS'(1);
    aus_next = (any_uncovered_seen && !first_q) || !cov_q;
    mark_res = cov_q || deg1_q ||
               ((current_choice != '0) && (current_choice <= TAG_BITS'(MASK_TAGS)) &&
                nt_q[cc_m1[TIDX_BITS-1:0]]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_choice     <= '0;
      any_uncovered_seen <= 1'b0;
    end else if (fin_fire) begin
      if (is_choose) begin
        current_choice <= best_tag;
      end
      if (is_mark) begin
        any_uncovered_seen <= aus_next;
      end
    end
  end

  // output register, freed as soon as the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_fire) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      chosen_tag       <= sel_tag;
      own_tags_out     <= own_q | tag_bit;
      load_added       <= add_load;
      edge_covered_out <= is_mark && mark_res;
      all_covered      <= is_mark && last_q && !aus_next;
    end
  end

`ifndef SYNTHESIS
  // scan stays within the tags in use
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> ((scan_tag != '0) && (scan_tag <= n_tags)))
    else $error("scan tag out of range");

  // the running best always comes from an earlier tag of the walk
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (best_tag < scan_tag))
    else $error("best tag ahead of scan");

  // a finished command always leaves a beat in the output register
  assert property (@(posedge clk) disable iff (rst)
    fin_fire |=> out_valid)
    else $error("result beat lost");

  // load is only reported for a real tag
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && load_added) |-> (chosen_tag != '0))
    else $error("load added without a tag");

  // the stored choice never exceeds the mask width
  assert property (@(posedge clk) disable iff (rst)
    current_choice <= TAG_BITS'(MASK_TAGS))
    else $error("current choice out of range");
`endif

endmodule

// File: sim/greedy_vertex_tag_chooser_tb.sv
module greedy_vertex_tag_chooser_tb
  import gvtc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // block configuration, kept equal to the instance parameters
  localparam int MAX_TAGS      = 16;
  localparam int LOAD_BITS     = 40;
  // longest busy stretch is a full tag scan plus accept and finish
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int IDLE_PCT      = 33;
  localparam int PRINT_CAP     = 40;
  // command codes the block must ignore
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
  localparam logic [TAG_BITS-1:0] TAG_NONE = '0;

  // one command beat as the sender sees it
  typedef struct packed {
    logic [2:0]           cmd;
    logic                 first;
    logic                 last;
    logic [MASK_TAGS-1:0] nbr;
    logic [MASK_TAGS-1:0] own;
    logic                 covered;
    logic                 deg1;
    logic [TAG_BITS-1:0]  seed;
  } vertex_beat_t;

  // one result beat
  typedef struct packed {
    logic [TAG_BITS-1:0]  tag;
    logic [MASK_TAGS-1:0] mask;
    logic                 added;
    logic                 edge_cov;
    logic                 all_cov;
  } tag_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wen = 1'b0;
  logic [TAG_BITS-1:0]  cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [2:0]           command = '0;
  logic                 first_item = 1'b0;
  logic                 last_item = 1'b0;
  logic [MASK_TAGS-1:0] neighbor_tags = '0;
  logic [MASK_TAGS-1:0] own_tags = '0;
  logic                 edge_covered = 1'b0;
  logic                 neighbor_degree_one = 1'b0;
  logic [TAG_BITS-1:0]  seed_tag = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [TAG_BITS-1:0]  chosen_tag;
  logic [MASK_TAGS-1:0] own_tags_out;
  logic                 load_added;
  logic                 edge_covered_out;
  logic                 all_covered;

  // mirror of the block state
  logic [TALLY_BITS-1:0] tally_mirror [MASK_TAGS];
  logic [LOAD_BITS-1:0]  load_mirror [MAX_TAGS];
  logic [TAG_BITS-1:0]   choice_mirror = '0;
  logic                  uncovered_mirror = 1'b0;
  logic [TAG_BITS-1:0]   tag_count_cfg = 5'd8;

  tag_result_t tag_results_due[$];
  tag_result_t latest_prediction;

  // pacing controls shared with the receiver process
  bit steady_flow = 1'b0;
  int holdoff_request = 0;
  int holdoff_left = 0;

  int beats_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int settings_written = 0;
  int pauses_taken = 0;
  int cycle_count = 0;

  greedy_vertex_tag_chooser #(
    .MAX_TAGS (MAX_TAGS),
    .LOAD_BITS(LOAD_BITS)
  ) DUT (
    .clk                (clk),
    .rst                (rst),
    .cfg_wen            (cfg_wen),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .command            (command),
    .first_item         (first_item),
    .last_item          (last_item),
    .neighbor_tags      (neighbor_tags),
    .own_tags           (own_tags),
    .edge_covered       (edge_covered),
    .neighbor_degree_one(neighbor_degree_one),
    .seed_tag           (seed_tag),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .chosen_tag         (chosen_tag),
    .own_tags_out       (own_tags_out),
    .load_added         (load_added),
    .edge_covered_out   (edge_covered_out),
    .all_covered        (all_covered)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // tags scanned are 1..n, n capped by the number of load counters
  function automatic int active_tags();
    return (tag_count_cfg > MAX_TAGS) ? MAX_TAGS : int'(tag_count_cfg);
  endfunction

  // loads hold at all ones
  function automatic void bump_load(input int t);
    if (load_mirror[t-1] != '1) load_mirror[t-1] = load_mirror[t-1] + LOAD_BITS'(1);
  endfunction

  // put tag t into the vertex mask, load grows only when the tag is new there
  function automatic void claim_tag(input int t, input logic [MASK_TAGS-1:0] own,
                                    inout tag_result_t r);
    r.tag = TAG_BITS'(t);
    if (t != 0) begin
      r.mask = own | (MASK_TAGS'(1) << (t - 1));
      if (!own[t-1]) begin
        bump_load(t);
        r.added = 1'b1;
      end
    end
  endfunction

  // applies one accepted beat to the mirror and queues its result, if any
  function automatic void compute_tag_result(input vertex_beat_t b);
    tag_result_t           r;
    int                    n;
    int                    best;
    logic [TALLY_BITS-1:0] top;
    bit                    emits;
    r = '0;
    r.mask = b.own;
    n = active_tags();
    best = 0;
    top = '0;
    emits = 1'b1;
    case (b.cmd)
      CMD_COUNT: begin
        emits = 1'b0;
        if (b.first) foreach (tally_mirror[i]) tally_mirror[i] = '0;
        // covered edges add nothing, tallies saturate
        if (!b.covered)
          for (int t = 1; t <= n; t++)
            if (b.nbr[t-1] && tally_mirror[t-1] != '1)
              tally_mirror[t-1] = tally_mirror[t-1] + TALLY_BITS'(1);
      end
      CMD_CHOOSE: begin
        for (int t = 1; t <= n; t++)
          if (tally_mirror[t-1] > top) top = tally_mirror[t-1];
        // highest tally, then least load, then lowest tag
        for (int t = 1; t <= n; t++)
          if (tally_mirror[t-1] == top &&
              (best == 0 || load_mirror[t-1] < load_mirror[best-1]))
            best = t;
        choice_mirror = TAG_BITS'(best);
        claim_tag(best, b.own, r);
      end
      CMD_MARK: begin
        r.edge_cov = 1'b1;
        if (b.first) uncovered_mirror = 1'b0;
        if (!b.covered) begin
          uncovered_mirror = 1'b1;
          r.edge_cov = b.deg1;
          // neighbor already holding the current choice covers the edge
          if (choice_mirror != TAG_NONE && choice_mirror <= MASK_TAGS &&
              b.nbr[choice_mirror-1])
            r.edge_cov = 1'b1;
        end
        r.all_cov = b.last && !uncovered_mirror;
      end
      CMD_LEAF: begin
        // least loaded among the neighbor's tags, current choice untouched
        for (int t = 1; t <= n; t++)
          if (b.nbr[t-1] && (best == 0 || load_mirror[t-1] < load_mirror[best-1]))
            best = t;
        claim_tag(best, b.own, r);
      end
      CMD_SEED: begin
        // out-of-range seed tags give an empty result
        if (b.seed >= 1 && b.seed <= n) begin
          bump_load(int'(b.seed));
          r.tag = b.seed;
          r.mask = b.own | (MASK_TAGS'(1) << (b.seed - 1));
          r.added = 1'b1;
        end
      end
      default: emits = 1'b0;
    endcase
    latest_prediction = r;
    if (emits) tag_results_due = {tag_results_due, r};
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  function automatic vertex_beat_t make_beat(input logic [2:0] cmd, input logic first,
                                             input logic last,
                                             input logic [MASK_TAGS-1:0] nbr,
                                             input logic [MASK_TAGS-1:0] own,
                                             input logic covered, input logic deg1,
                                             input logic [TAG_BITS-1:0] seed);
    vertex_beat_t b;
    b.cmd = cmd;
    b.first = first;
    b.last = last;
    b.nbr = nbr;
    b.own = own;
    b.covered = covered;
    b.deg1 = deg1;
    b.seed = seed;
    return b;
  endfunction

  // offers one beat, predicts it at the edge where it is taken
  task automatic send_beat(input vertex_beat_t b);
    // random gap before the beat, never while the stream runs steady
    if (!steady_flow && $urandom_range(99) < IDLE_PCT)
      repeat ($urandom_range(2, 1)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    @(negedge clk);
    in_valid <= 1'b1;
    command <= b.cmd;
    first_item <= b.first;
    last_item <= b.last;
    neighbor_tags <= b.nbr;
    own_tags <= b.own;
    edge_covered <= b.covered;
    neighbor_degree_one <= b.deg1;
    seed_tag <= b.seed;
    do @(posedge clk); while (in_stall);
    compute_tag_result(b);
    if (b.cmd <= CMD_SEED) beats_sent++;
  endtask

  // sender stops and waits for every outstanding result beat
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tag_results_due.size() != 0) @(posedge clk);
  endtask

  // register write only once the block has gone quiet
  task automatic write_tag_count(input logic [TAG_BITS-1:0] value);
    wait_results_drained();
    // a trailing count beat may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen <= 1'b0;
    tag_count_cfg = value;
    settings_written++;
  endtask

  // mostly masks inside the active tags, with sparse and full ones mixed in
  function automatic logic [MASK_TAGS-1:0] random_mask(input int n);
    int lim;
    lim = (n < 1) ? 1 : n;
    case ($urandom_range(5))
      0: return MASK_TAGS'($urandom);
      1: return '0;
      2: return '1;
      3, 4: return MASK_TAGS'(1) << $urandom_range(lim - 1);
      default: return (MASK_TAGS'(1) << $urandom_range(lim - 1)) |
                      (MASK_TAGS'(1) << $urandom_range(lim - 1));
    endcase
  endfunction

  // occasional junk beat: any command, any fields
  task automatic maybe_noise();
    if ($urandom_range(99) < 8)
      send_beat(make_beat(3'($urandom_range(7)), 1'($urandom), 1'($urandom),
                          MASK_TAGS'($urandom), MASK_TAGS'($urandom), 1'($urandom),
                          1'($urandom), TAG_BITS'($urandom)));
  endtask

  // one vertex: optional seed, count pass, choose, mark pass, then leaf assigns
  task automatic run_vertex_session();
    vertex_beat_t         hood[$];
    vertex_beat_t         b;
    int                   k;
    int                   n;
    int                   lim;
    bit                   broken;
    logic [MASK_TAGS-1:0] own;
    n = active_tags();
    lim = (n < 1) ? 1 : n;
    k = ($urandom_range(9) == 0) ? $urandom_range(24, 8) : $urandom_range(6, 1);
    broken = ($urandom_range(9) == 0);
    own = ($urandom_range(2) == 0) ? '0 : random_mask(n);
    for (int i = 0; i < k; i++) begin
      b = '0;
      b.nbr = random_mask(n);
      b.covered = ($urandom_range(3) == 0);
      b.deg1 = ($urandom_range(3) == 0);
      b.seed = TAG_BITS'($urandom);
      hood = {hood, b};
    end
    // seeding, out-of-range tags now and then
    if ($urandom_range(4) == 0)
      send_beat(make_beat(CMD_SEED, 1'b0, 1'b0, random_mask(n), own, 1'b0, 1'b0,
                          ($urandom_range(3) == 0) ? TAG_BITS'($urandom_range(31)) :
                                                     TAG_BITS'($urandom_range(lim, 1))));
    foreach (hood[i]) begin
      b = hood[i];
      b.cmd = CMD_COUNT;
      b.own = own;
      b.first = broken ? 1'($urandom) : (i == 0);
      b.last = 1'($urandom);
      send_beat(b);
      maybe_noise();
    end
    send_beat(make_beat(CMD_CHOOSE, 1'($urandom), 1'($urandom), MASK_TAGS'($urandom),
                        own, 1'($urandom), 1'($urandom), TAG_BITS'($urandom)));
    // the vertex keeps the mask the block hands back
    own = latest_prediction.mask;
    foreach (hood[i]) begin
      b = hood[i];
      b.cmd = CMD_MARK;
      b.own = own;
      b.first = broken ? 1'($urandom) : (i == 0);
      b.last = broken ? 1'($urandom) : (i == k - 1);
      send_beat(b);
      maybe_noise();
    end
    foreach (hood[i])
      if (hood[i].deg1 && $urandom_range(1) == 0) begin
        b = hood[i];
        b.cmd = CMD_LEAF;
        b.own = random_mask(n);
        send_beat(b);
      end
  endtask

  // ---------------------------------------------------------------------------
  // receiver side
  // ---------------------------------------------------------------------------

  // stall pacing, with a counted hold-off on request
  always @(negedge clk) begin
    if (holdoff_request != 0) begin
      holdoff_left = holdoff_request;
      holdoff_request = 0;
    end
    if (holdoff_left > 0) begin
      out_stall <= 1'b1;
      holdoff_left--;
    end else if (steady_flow) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("mismatch on %s at result %0d: got %0h, expected %0h",
               field, results_seen, got, want);
  endtask

  // each result beat against the oldest prediction
  always @(posedge clk) begin
    tag_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (tag_results_due.size() == 0) begin
        report_mismatch("result beat with nothing due", 32'(chosen_tag), 32'd0);
      end else begin
        want = tag_results_due.pop_front();
        if (chosen_tag !== want.tag)
          report_mismatch("chosen_tag", 32'(chosen_tag), 32'(want.tag));
        if (own_tags_out !== want.mask)
          report_mismatch("own_tags_out", 32'(own_tags_out), 32'(want.mask));
        if (load_added !== want.added)
          report_mismatch("load_added", 32'(load_added), 32'(want.added));
        if (edge_covered_out !== want.edge_cov)
          report_mismatch("edge_covered_out", 32'(edge_covered_out), 32'(want.edge_cov));
        if (all_covered !== want.all_cov)
          report_mismatch("all_covered", 32'(all_covered), 32'(want.all_cov));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due",
               cycle_count, tag_results_due.size());
      $display("greedy_vertex_tag_chooser_tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset tag count of 8, blank tallies and loads: every tag ties
  task automatic test_reset_state();
    send_beat(make_beat(CMD_CHOOSE, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, TAG_NONE));
    send_beat(make_beat(CMD_LEAF, 1'b0, 1'b0, '1, '0, 1'b0, 1'b0, TAG_NONE));
    send_beat(make_beat(CMD_MARK, 1'b1, 1'b1, '0, '0, 1'b0, 1'b0, TAG_NONE));
  endtask

  // seeds at both ends of the tag range and outside it
  task automatic test_seed_limits();
    write_tag_count(5'd16);
    send_beat(make_beat(CMD_SEED, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 5'd16));
    send_beat(make_beat(CMD_SEED, 1'b0, 1'b0, '1, '1, 1'b1, 1'b1, TAG_NONE));
    send_beat(make_beat(CMD_SEED, 1'b0, 1'b0, '0, 16'h5555, 1'b0, 1'b0, 5'd31));
    // tag already in the mask still reports load
    send_beat(make_beat(CMD_SEED, 1'b0, 1'b0, '0, 16'h0001, 1'b0, 1'b0, 5'd1));
  endtask

  // tallies from uncovered neighbors only, choose with and without a new tag
  task automatic test_count_choose();
    send_beat(make_beat(CMD_COUNT, 1'b1, 1'b0, '1, '0, 1'b0, 1'b0, TAG_NONE));
    send_beat(make_beat(CMD_COUNT, 1'b0, 1'b0, 16'h8000, '0, 1'b0, 1'b0, TAG_NONE));
    send_beat(make_beat(CMD_COUNT, 1'b0, 1'b1, '1, '0, 1'b1, 1'b0, TAG_NONE));
    send_beat(make_beat(CMD_CHOOSE, 1'b0, 1'b0, '0, '1, 1'b0, 1'b0, TAG_NONE));
    send_beat(make_beat(CMD_CHOOSE, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, TAG_NONE));
  endtask

  // leaf with no usable tag, then between the two ends of the mask
  task automatic test_leaf_assign();
    send_beat(make_beat(CMD_LEAF, 1'b0, 1'b0, '0, 16'hAAAA, 1'b0, 1'b1, TAG_NONE));
    send_beat(make_beat(CMD_LEAF, 1'b0, 1'b0, 16'h8001, '0, 1'b0, 1'b1, TAG_NONE));
  endtask

  // covered edges, choice hit, degree-one rescue, all-covered report
  task automatic test_mark_cover();
    send_beat(make_beat(CMD_MARK, 1'b1, 1'b0, '0, '0, 1'b1, 1'b0, TAG_NONE));
    send_beat(make_beat(CMD_MARK, 1'b0, 1'b0, 16'h8000, '0, 1'b0, 1'b0, TAG_NONE));
    send_beat(make_beat(CMD_MARK, 1'b0, 1'b0, 16'h0001, '0, 1'b0, 1'b0, TAG_NONE));
    send_beat(make_beat(CMD_MARK, 1'b0, 1'b1, '0, '0, 1'b0, 1'b1, TAG_NONE));
    send_beat(make_beat(CMD_MARK, 1'b1, 1'b1, '1, '1, 1'b1, 1'b0, TAG_NONE));
  endtask

  // zero tags in use, ignored commands, then a count above the counter range
  task automatic test_no_tags();
    write_tag_count(5'd0);
    send_beat(make_beat(CMD_CHOOSE, 1'b0, 1'b0, '1, '0, 1'b0, 1'b0, TAG_NONE));
    // choice is now empty, only degree one can cover
    send_beat(make_beat(CMD_MARK, 1'b1, 1'b1, '1, '0, 1'b0, 1'b0, TAG_NONE));
    send_beat(make_beat(CMD_LEAF, 1'b0, 1'b0, '1, '0, 1'b0, 1'b1, TAG_NONE));
    send_beat(make_beat(CMD_SEED, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 5'd1));
    send_beat(make_beat(CMD_UNUSED_LO, 1'b1, 1'b1, '1, '1, 1'b0, 1'b1, 5'd3));
    send_beat(make_beat(CMD_UNUSED_HI, 1'b1, 1'b1, '1, '1, 1'b1, 1'b1, 5'd31));
    write_tag_count(5'd31);
    send_beat(make_beat(CMD_COUNT, 1'b1, 1'b0, '1, '0, 1'b0, 1'b0, TAG_NONE));
    send_beat(make_beat(CMD_CHOOSE, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, TAG_NONE));
  endtask

  // receiver holds off while the sender keeps pushing, block backs up
  task automatic test_output_backpressure();
    write_tag_count(5'd16);
    holdoff_request = 250;
    for (int i = 0; i < 40; i++)
      send_beat(make_beat((i % 2 == 0) ? CMD_SEED : CMD_MARK, 1'($urandom), 1'($urandom),
                          MASK_TAGS'($urandom), MASK_TAGS'($urandom), 1'($urandom),
                          1'($urandom), TAG_BITS'($urandom_range(16, 1))));
    // sender waits out every result before going on
    wait_results_drained();
    pauses_taken++;
  endtask

  // no sender gaps and no receiver stalls
  task automatic test_steady_stream();
    int start;
    start = beats_sent;
    steady_flow = 1'b1;
    while (beats_sent - start < 150) run_vertex_session();
    steady_flow = 1'b0;
  endtask

  // random vertex sessions across several tag counts
  task automatic test_random_traffic();
    int budgets [6];
    int counts [6];
    int start;
    counts = '{16, 3, 1, 31, 0, 0};
    budgets = '{300, 250, 150, 250, 60, 300};
    counts[5] = $urandom_range(15, 2);
    foreach (counts[p]) begin
      write_tag_count(TAG_BITS'(counts[p]));
      start = beats_sent;
      while (beats_sent - start < budgets[p]) begin
        run_vertex_session();
        if ($urandom_range(19) == 0) begin
          wait_results_drained();
          pauses_taken++;
        end
      end
    end
  endtask

  initial begin
    foreach (tally_mirror[i]) tally_mirror[i] = '0;
    foreach (load_mirror[i]) load_mirror[i] = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_seed_limits();
    test_count_choose();
    test_leaf_assign();
    test_mark_cover();
    test_no_tags();
    test_output_backpressure();
    test_steady_stream();
    test_random_traffic();

    // drain, then let any straggling beat show up
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d command beats and checked %0d result beats over %0d tag-count settings",
             beats_sent, results_seen, settings_written);
    $display("included one long output hold-off, %0d drain pauses, %0d mismatches",
             pauses_taken, mismatches);
    if (mismatches == 0) begin
      $display("greedy_vertex_tag_chooser_tb passed");
    end else begin
      $display("greedy_vertex_tag_chooser_tb failed");
    end
    $finish;
  end

endmodule
